>>> design/rxs_pkg.sv
package rxs_pkg;

  localparam int unsigned WordBytes = 4;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned KeyIdxW   = 2;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgKeyWord = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPadMode = 2'd1;

  localparam logic [CountW-1:0] CountFull = 3'(WordBytes);

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } opcode_e;

endpackage

>>> design/rxs_datapath.sv
module rxs_datapath
  import rxs_pkg::*;
(
  input  logic                opcode_i,
  input  logic [WordW-1:0]    data_word_i,
  input  logic [CountW-1:0]   byte_count_i,
  input  logic [KeyIdxW-1:0]  key_idx_i,
  input  logic [WordW-1:0]    key_word_i,
  input  logic                pad_mode_i,
  output logic [WordW-1:0]    result_word_o,
  output logic [CountW-1:0]   result_bytes_o,
  output logic                error_flag_o
);

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] d;
    d = {x, x} >> r;
    return d[31:0];
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] r);
    logic [4:0] nr;
    nr = 5'd0 - r;
    return ror32(x, nr);
  endfunction

  function automatic logic [7:0] ror8(input logic [7:0] x, input logic [2:0] r);
    logic [15:0] d;
    d = {x, x} >> r;
    return d[7:0];
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] x, input logic [2:0] r);
    logic [2:0] nr;
    nr = 3'd0 - r;
    return ror8(x, nr);
  endfunction

  logic              decrypt;
  logic [CountW-1:0] cnt;
  logic [4:0]        amt;
  logic [WordW-1:0]  masked;
  logic [WordW-1:0]  byte_res;
  logic [7:0]        kb;
  logic [7:0]        db;

  assign decrypt = (opcode_i == OpDecrypt);
  assign cnt     = (byte_count_i > CountFull) ? CountFull : byte_count_i;
  assign amt     = key_word_i[{key_idx_i, 3'b000} +: 5];

  always_comb begin
    masked   = '0;
    byte_res = '0;
    kb       = '0;
    db       = '0;
    for (int n = 0; n < WordBytes; n++) begin
      kb = key_word_i[8*n +: 8];
      db = data_word_i[8*n +: 8];
      if (CountW'(n) < cnt) begin
        masked[8*n +: 8] = db;
        if (decrypt) begin
          byte_res[8*n +: 8] = rol8(db ^ kb, kb[2:0]);
        end else begin
          byte_res[8*n +: 8] = ror8(db, kb[2:0]) ^ kb;
        end
      end
    end
  end

  always_comb begin
    result_word_o  = '0;
    result_bytes_o = '0;
    error_flag_o   = 1'b0;
    if (cnt == CountFull) begin
      result_bytes_o = CountFull;
      if (decrypt) begin
        result_word_o = rol32(data_word_i ^ key_word_i, amt);
      end else begin
        result_word_o = ror32(data_word_i, amt) ^ key_word_i;
      end
    end else if (cnt != '0) begin
      if (pad_mode_i) begin
        if (decrypt) begin
          error_flag_o = 1'b1;
        end else begin
          result_word_o  = ror32(masked, amt) ^ key_word_i;
          result_bytes_o = CountFull;
        end
      end else begin
        result_word_o  = byte_res;
        result_bytes_o = cnt;
      end
    end
  end

endmodule

>>> design/rotate_xor_stream_scrambler.sv
// Rotate-XOR stream scrambler.
// Input channel (in_valid_i/in_ready_o) takes one message chunk per beat:
// opcode, up to four bytes, byte count and a first-chunk flag.
// Output channel (out_valid_o/out_ready_i) returns one result beat per
// input beat, in order.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the key word
// (index 0) or pad mode (index 1); it is always ready. Write it only
// while no beats are in flight.
// A beat enters the input register when accepted and moves on to the
// result register, which drives out_valid_o. The block takes one beat
// per cycle while the receiver is ready; the combinational rotate and
// XOR sit between the two registers.
// The key byte index is updated at input accept (restarted on a first
// chunk, advanced past a full word), so back-to-back beats see the right key byte.
// Reset clears the key word, pad mode, key index and both valid flags.
// When the receiver stalls, the result register holds, the input
// register holds behind it, and in_ready_o drops once both are full.
module rotate_xor_stream_scrambler
  import rxs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [WordW-1:0]   data_word_i,
  input  logic [CountW-1:0]  byte_count_i,
  input  logic               first_chunk_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WordW-1:0]   result_word_o,
  output logic [CountW-1:0]  result_bytes_o,
  output logic               error_flag_o
);

  logic [WordW-1:0]   key_word_q;
  logic               pad_mode_q;
  logic [KeyIdxW-1:0] key_idx_q, key_idx_d, idx_base;

  logic               s1_valid_q;
  logic               s1_opcode_q;
  logic [WordW-1:0]   s1_data_q;
  logic [CountW-1:0]  s1_count_q;
  logic [KeyIdxW-1:0] s1_idx_q;

  logic               out_valid_q;
  logic [WordW-1:0]   out_word_q;
  logic [CountW-1:0]  out_bytes_q;
  logic               out_err_q;

  logic [WordW-1:0]   calc_word;
  logic [CountW-1:0]  calc_bytes;
  logic               calc_err;

  logic out_free, s1_move, in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_word_q <= '0;
      pad_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgKeyWord: key_word_q <= cfg_data_i;
        CfgPadMode: pad_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // restart on first chunk; advance only on full words
  assign idx_base  = first_chunk_i ? '0 : key_idx_q;
  assign key_idx_d = (byte_count_i >= CountFull) ? idx_base + KeyIdxW'(1) : idx_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_idx_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        key_idx_q <= key_idx_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_opcode_q <= opcode_i;
      s1_data_q   <= data_word_i;
      s1_count_q  <= byte_count_i;
      s1_idx_q    <= idx_base;
    end
  end

  rxs_datapath u_datapath (
    .opcode_i       (s1_opcode_q),
    .data_word_i    (s1_data_q),
    .byte_count_i   (s1_count_q),
    .key_idx_i      (s1_idx_q),
    .key_word_i     (key_word_q),
    .pad_mode_i     (pad_mode_q),
    .result_word_o  (calc_word),
    .result_bytes_o (calc_bytes),
    .error_flag_o   (calc_err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_word_q  <= calc_word;
      out_bytes_q <= calc_bytes;
      out_err_q   <= calc_err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_word_o  = out_word_q;
  assign result_bytes_o = out_bytes_q;
  assign error_flag_o   = out_err_q;

endmodule

>>> sim/rotate_xor_stream_scrambler_tb.sv
`timescale 1ns / 100ps

module rotate_xor_stream_scrambler_tb;
  import rxs_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    opcode_e           op;
    logic [WordW-1:0]  data;
    logic [CountW-1:0] count;
    logic              first;
  } chunk_t;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CountW-1:0] bytes;
    logic              err;
  } result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i    = '0;
  logic [WordW-1:0]   cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               opcode_i       = 1'b0;
  logic [WordW-1:0]   data_word_i    = '0;
  logic [CountW-1:0]  byte_count_i   = '0;
  logic               first_chunk_i  = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [WordW-1:0]   result_word_o;
  logic [CountW-1:0]  result_bytes_o;
  logic               error_flag_o;

  logic [WordW-1:0]   key_reg     = '0;
  logic               pad_reg     = 1'b0;
  logic [KeyIdxW-1:0] cur_key_sel = '0;

  result_t     pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          steady         = 1'b0;

  rotate_xor_stream_scrambler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .data_word_i    (data_word_i),
    .byte_count_i   (byte_count_i),
    .first_chunk_i  (first_chunk_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_word_o  (result_word_o),
    .result_bytes_o (result_bytes_o),
    .error_flag_o   (error_flag_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic result_t scramble_chunk(chunk_t c);
    result_t           r;
    logic [CountW-1:0] cnt;
    logic [4:0]        amt;
    logic [WordW-1:0]  x;
    logic [63:0]       dbl;
    logic [7:0]        kb;
    logic [7:0]        b;
    logic [7:0]        y;
    logic [15:0]       d8;
    int                n;
    r = '0;
    if (c.first) cur_key_sel = '0;
    cnt = (c.count > CountFull) ? CountFull : c.count;
    if (cnt == CountFull) begin
      amt = key_reg[cur_key_sel*8 +: 5];
      if (c.op == OpDecrypt) begin
        x = c.data ^ key_reg;
        dbl = {x, x} << amt;
        r.word = dbl[63:32];
      end else begin
        dbl = {c.data, c.data} >> amt;
        r.word = dbl[31:0] ^ key_reg;
      end
      r.bytes = CountFull;
      cur_key_sel = cur_key_sel + 1'b1;
    end else if (cnt != 0) begin
      if (pad_reg) begin
        if (c.op == OpDecrypt) begin
          r.err = 1'b1;
        end else begin
          x = c.data & ((32'd1 << (cnt * 8)) - 32'd1);
          amt = key_reg[cur_key_sel*8 +: 5];
          dbl = {x, x} >> amt;
          r.word = dbl[31:0] ^ key_reg;
          r.bytes = CountFull;
        end
      end else begin
        for (n = 0; n < cnt; n++) begin
          kb = key_reg[n*8 +: 8];
          b  = c.data[n*8 +: 8];
          if (c.op == OpDecrypt) begin
            y  = b ^ kb;
            d8 = {y, y} << kb[2:0];
            y  = d8[15:8];
          end else begin
            d8 = {b, b} >> kb[2:0];
            y  = d8[7:0] ^ kb;
          end
          r.word[n*8 +: 8] = y;
        end
        r.bytes = cnt;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result beat: word %h bytes %0d err %0b", $time,
                 result_word_o, result_bytes_o, error_flag_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (result_word_o !== exp_r.word) begin
          mismatch_count++;
          $display("%0t result_word expected %h actual %h", $time, exp_r.word,
                   result_word_o);
        end
        if (result_bytes_o !== exp_r.bytes) begin
          mismatch_count++;
          $display("%0t result_bytes expected %0d actual %0d", $time, exp_r.bytes,
                   result_bytes_o);
        end
        if (error_flag_o !== exp_r.err) begin
          mismatch_count++;
          $display("%0t error_flag expected %0b actual %0b", $time, exp_r.err,
                   error_flag_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("rotate_xor_stream_scrambler: mismatch");
      $finish;
    end
  end

  task automatic send_chunk(opcode_e op, logic [WordW-1:0] data, logic [CountW-1:0] count,
                            logic first);
    chunk_t c;
    c = '{op: op, data: data, count: count, first: first};
    if (!steady && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    data_word_i   <= data;
    byte_count_i  <= count;
    first_chunk_i <= first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(scramble_chunk(c));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] value);
    wait_drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgKeyWord) key_reg = value;
    else if (idx == CfgPadMode) pad_reg = value[0];
  endtask

  task automatic test_reset_state();
    send_chunk(OpEncrypt, 32'h1234_5678, CountFull, 1'b1);
    send_chunk(OpDecrypt, 32'h00AB_CDEF, 3'd3, 1'b0);
  endtask

  task automatic test_full_words();
    write_reg(CfgKeyWord, 32'h1F08_0107);
    send_chunk(OpEncrypt, 32'h0000_0000, CountFull, 1'b1);
    send_chunk(OpEncrypt, 32'hFFFF_FFFF, CountFull, 1'b0);
    send_chunk(OpEncrypt, 32'hDEAD_BEEF, CountFull, 1'b0);
    send_chunk(OpEncrypt, 32'h8000_0001, CountFull, 1'b0);
    send_chunk(OpEncrypt, 32'h0123_4567, CountFull, 1'b0);
    // restart mid-message, then decrypt
    send_chunk(OpDecrypt, 32'hCAFE_F00D, CountFull, 1'b1);
    send_chunk(OpDecrypt, 32'hFFFF_FFFF, CountFull, 1'b0);
  endtask

  task automatic test_byte_tail();
    write_reg(CfgKeyWord, 32'hFFFF_FFFF);
    send_chunk(OpEncrypt, 32'hFFFF_FF81, 3'd1, 1'b1);
    send_chunk(OpEncrypt, 32'h1234_A55A, 3'd2, 1'b0);
    send_chunk(OpDecrypt, 32'hFF00_FF00, 3'd3, 1'b0);
    send_chunk(OpEncrypt, 32'h7777_7777, 3'd0, 1'b0);
    send_chunk(OpEncrypt, 32'h0F0F_0F0F, 3'd5, 1'b0);
    send_chunk(OpDecrypt, 32'hA5A5_A5A5, 3'd6, 1'b0);
    send_chunk(OpEncrypt, 32'h5A5A_5A5A, 3'd7, 1'b0);
    send_chunk(OpDecrypt, 32'h0000_0000, 3'd1, 1'b1);
  endtask

  task automatic test_pad_tail();
    write_reg(CfgPadMode, 32'd1);
    write_reg(CfgKeyWord, 32'h0310_1B05);
    send_chunk(OpEncrypt, 32'h1111_2222, CountFull, 1'b1);
    send_chunk(OpEncrypt, 32'hFFFF_FFFF, 3'd3, 1'b0);
    send_chunk(OpEncrypt, 32'hFFFF_FFFF, 3'd1, 1'b1);
    send_chunk(OpDecrypt, 32'hFFFF_FFFF, 3'd2, 1'b0);
    send_chunk(OpEncrypt, 32'h0000_0000, 3'd0, 1'b0);
  endtask

  task automatic send_message(ref int unsigned sent);
    opcode_e op;
    int      words;
    int      w;
    op    = opcode_e'($urandom_range(1));
    words = $urandom_range(0, 6);
    for (w = 0; w < words; w++) begin
      send_chunk(op, $urandom, CountFull, w == 0);
      sent++;
    end
    if (words == 0 || $urandom_range(1)) begin
      send_chunk(op, $urandom, 3'($urandom_range(1, 3)), words == 0);
      sent++;
    end
  endtask

  task automatic run_phase(logic [WordW-1:0] key, logic pad, int unsigned n_items,
                           bit quiet);
    int unsigned sent;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    write_reg(CfgKeyWord, key);
    write_reg(CfgPadMode, {31'd0, pad});
    steady = quiet;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        send_message(sent);
      end else begin
        send_chunk(opcode_e'($urandom_range(1)), $urandom, 3'($urandom_range(0, 7)),
                   1'($urandom_range(1)));
        sent++;
      end
      if (!paused && sent > n_items / 2) begin
        wait_drain();
        paused = 1'b1;
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_random_messages();
    run_phase(32'h0000_0000, 1'b0, 75, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b1, 75, 1'b0);
    run_phase($urandom, 1'b0, 75, 1'b1);
    run_phase($urandom, 1'b1, 75, 1'b0);
    run_phase($urandom, 1'b0, 75, 1'b0);
    run_phase($urandom, 1'b1, 75, 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_full_words();
    test_byte_tail();
    test_pad_tail();
    test_random_messages();
    wait_drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rotate_xor_stream_scrambler: match");
    end else begin
      $display("rotate_xor_stream_scrambler: mismatch");
    end
    $finish;
  end

endmodule
